### design/assert_macros.svh
// Assertion macros used by the predictor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LMS_AP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition in one cycle implies a condition in the next cycle.
`define LMS_AP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lms_ap_pkg.sv
// Package of the LMS adaptive predictor: widths, codes, microcode ROM and exp table.
package lms_ap_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int WEIGHT_W   = 32;
    localparam int COEF_W     = 16;
    localparam int ERR_W      = 17;
    localparam int SE_W       = 34;
    localparam int MUL_A_W    = 42;
    localparam int MUL_B_W    = 18;
    localparam int MUL_W      = MUL_A_W + MUL_B_W;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Q4.28 fixed point: weight 1.0, and the prediction rounding point
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_ONE = 32'sh1000_0000;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 32'sh8000_0000;
    localparam int PRED_SHIFT = 28;

    // Update term: step*error*sample in Q3.46, rounded to Q4.28
    localparam int UPD_SHIFT = 18;
    localparam int UPD_D_W   = 34;

    // Variable step: alpha*error^2 is Q10.38 in 48 bits; the table spans [0, 8)
    localparam int GAIN_PROD_W = 48;
    localparam int EXP_SHIFT   = 41;
    localparam int EXP_DEPTH   = 256;
    localparam int EXP_IDX_W   = $clog2(EXP_DEPTH);
    localparam int EXP_W       = 17;
    localparam logic [EXP_W-1:0] EXP_ONE = 17'd65536;

    localparam logic [COEF_W-1:0] FIXED_STEP_RST = 16'd655;
    localparam logic [COEF_W-1:0] EXP_GAIN_RST   = 16'd256;
    localparam logic [COEF_W-1:0] STEP_CEIL_RST  = 16'd655;

    // Taylor terms of exp(-8/EXP_DEPTH) in Q0.32, each one truncated
    localparam logic [63:0] EXP_T0  = 64'd1 << 32;
    localparam logic [63:0] EXP_T1  = (EXP_T0 * 64'd8) / (64'(EXP_DEPTH) * 64'd1);
    localparam logic [63:0] EXP_T2  = (EXP_T1 * 64'd8) / (64'(EXP_DEPTH) * 64'd2);
    localparam logic [63:0] EXP_T3  = (EXP_T2 * 64'd8) / (64'(EXP_DEPTH) * 64'd3);
    localparam logic [63:0] EXP_T4  = (EXP_T3 * 64'd8) / (64'(EXP_DEPTH) * 64'd4);
    localparam logic [63:0] EXP_T5  = (EXP_T4 * 64'd8) / (64'(EXP_DEPTH) * 64'd5);
    localparam logic [63:0] EXP_T6  = (EXP_T5 * 64'd8) / (64'(EXP_DEPTH) * 64'd6);
    localparam logic [63:0] EXP_T7  = (EXP_T6 * 64'd8) / (64'(EXP_DEPTH) * 64'd7);
    localparam logic [63:0] EXP_T8  = (EXP_T7 * 64'd8) / (64'(EXP_DEPTH) * 64'd8);
    localparam logic [63:0] EXP_T9  = (EXP_T8 * 64'd8) / (64'(EXP_DEPTH) * 64'd9);
    localparam logic [63:0] EXP_T10 = (EXP_T9 * 64'd8) / (64'(EXP_DEPTH) * 64'd10);
    localparam logic [63:0] EXP_T11 = (EXP_T10 * 64'd8) / (64'(EXP_DEPTH) * 64'd11);
    localparam logic [63:0] EXP_RATIO =
        (EXP_T0 + EXP_T2 + EXP_T4 + EXP_T6 + EXP_T8 + EXP_T10)
        - (EXP_T1 + EXP_T3 + EXP_T5 + EXP_T7 + EXP_T9 + EXP_T11);

    typedef enum logic [1:0] {
        REG_MODE,
        REG_FIXED_STEP,
        REG_EXP_GAIN,
        REG_STEP_CEIL
    } reg_idx_t;

    typedef logic [EXP_W-1:0] exp_rom_t [EXP_DEPTH];

    // Microprogram addresses
    typedef enum logic [3:0] {
        UP_IDLE,
        UP_PMAC,
        UP_PDRAIN,
        UP_PRED,
        UP_VSQ,
        UP_VGAIN,
        UP_VIDX,
        UP_VCEIL,
        UP_VSTEP,
        UP_USE,
        UP_USE_HOLD,
        UP_UMAC,
        UP_UDRAIN,
        UP_SHIFT,
        UP_OUT
    } upc_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_WP,
        MUL_EE,
        MUL_GAIN,
        MUL_DEPTH,
        MUL_CEIL,
        MUL_SE,
        MUL_UPD
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_PRED,
        ACT_BIG,
        ACT_STEP,
        ACT_SE,
        ACT_SHIFT,
        ACT_OUT
    } act_t;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_GOTO,
        SEQ_LOOP,
        SEQ_WAIT_IN,
        SEQ_WAIT_OUT,
        SEQ_JMP_FIXED
    } seq_t;

    typedef struct packed {
        mul_sel_t mul;
        act_t     act;
        logic     adv;
        logic     rewind;
        logic     mac;
        logic     upd;
        seq_t     seq;
        upc_t     target;
    } ucode_t;

    // Control store: one word per microprogram step
    function automatic ucode_t ucode_rom(upc_t pc);
        ucode_t uc;
        uc = '{mul: MUL_NONE, act: ACT_NONE, adv: 1'b0, rewind: 1'b0, mac: 1'b0,
               upd: 1'b0, seq: SEQ_NEXT, target: UP_IDLE};
        case (pc)
            UP_IDLE:
            begin
                uc.act = ACT_LOAD;
                uc.seq = SEQ_WAIT_IN;
            end
            UP_PMAC:
            begin
                uc.mul = MUL_WP;
                uc.adv = 1'b1;
                uc.mac = 1'b1;
                uc.seq = SEQ_LOOP;
            end
            UP_PDRAIN: uc.seq = SEQ_NEXT;
            UP_PRED:
            begin
                uc.act    = ACT_PRED;
                uc.rewind = 1'b1;
                uc.seq    = SEQ_JMP_FIXED;
                uc.target = UP_USE;
            end
            UP_VSQ:   uc.mul = MUL_EE;
            UP_VGAIN: uc.mul = MUL_GAIN;
            UP_VIDX:
            begin
                uc.mul = MUL_DEPTH;
                uc.act = ACT_BIG;
            end
            UP_VCEIL:    uc.mul = MUL_CEIL;
            UP_VSTEP:    uc.act = ACT_STEP;
            UP_USE:      uc.mul = MUL_SE;
            UP_USE_HOLD: uc.act = ACT_SE;
            UP_UMAC:
            begin
                uc.mul = MUL_UPD;
                uc.adv = 1'b1;
                uc.upd = 1'b1;
                uc.seq = SEQ_LOOP;
            end
            UP_UDRAIN: uc.seq = SEQ_NEXT;
            UP_SHIFT:  uc.act = ACT_SHIFT;
            UP_OUT:
            begin
                uc.act    = ACT_OUT;
                uc.rewind = 1'b1;
                uc.seq    = SEQ_WAIT_OUT;
                uc.target = UP_IDLE;
            end
            default: uc.seq = SEQ_GOTO;
        endcase
        return uc;
    endfunction

    // exp(-8k/EXP_DEPTH) in Q1.16 by repeated multiplication with the Taylor ratio
    function automatic exp_rom_t build_exp_rom();
        logic [63:0] e;
        exp_rom_t    rom;
        e = 64'd1 << 32;
        for (int k = 0; k < EXP_DEPTH; k++)
        begin
            if (k > 0)
                e = (e * EXP_RATIO + (64'd1 << 31)) >> 32;
            rom[k] = EXP_W'((e + (64'd1 << 15)) >> 16);
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

### design/lms_adaptive_predictor_unit.sv
// Top level of the LMS adaptive predictor: microcoded sequencer and shared MAC datapath.
//
//   channel   | role          | payload
//   ----------+---------------+------------------------------------------
//   s_axis    | sample in     | tdata[15:0] = sample (signed Q1.15)
//   m_axis    | prediction out| tdata[15:0] = prediction (signed Q1.15)
//   apb       | registers     | 0 mode, 1 fixed_step, 2 exp_gain, 3 step_ceiling
//
// Per sample the one shared 42x18 multiplier walks the taps once for the prediction
// and once for the update; variable-step mode computes the step in between.
// Reset loads the register defaults, weight 0 = 1.0 and an all-zero delay line.
// A result waits in the output register; the next sample is taken meanwhile and
// the sequencer holds only at its last step while that register is still full.
`include "assert_macros.svh"

module lms_adaptive_predictor_unit #(
    parameter int TAPS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lms_ap_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [lms_ap_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [lms_ap_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                 pready,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [lms_ap_pkg::SAMPLE_W-1:0]      s_axis_tdata,   // [15:0] sample
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [lms_ap_pkg::SAMPLE_W-1:0]      m_axis_tdata    // [15:0] prediction
);

    import lms_ap_pkg::*;

    localparam int TW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ACC_W = 49 + TW;
    localparam int Q_W   = ACC_W - PRED_SHIFT;
    localparam logic [TW-1:0] LAST = TW'(TAPS - 1);
    localparam logic signed [ACC_W-1:0] ACC_HALF =
        {{(ACC_W - PRED_SHIFT){1'b0}}, 1'b1, {(PRED_SHIFT - 1){1'b0}}};
    localparam logic signed [MUL_W-1:0] UPD_HALF =
        {{(MUL_W - UPD_SHIFT){1'b0}}, 1'b1, {(UPD_SHIFT - 1){1'b0}}};

    // Sequencer
    upc_t   upc_reg, upc_next;
    ucode_t uc;
    logic [TW-1:0] cnt_reg, cnt_next;

    // Configuration registers
    logic              mode_reg;
    logic [COEF_W-1:0] fixed_step_reg;
    logic [COEF_W-1:0] exp_gain_reg;
    logic [COEF_W-1:0] step_ceil_reg;
    logic              cfg_wr;

    // Address counters for the tap walk and the circular delay line
    logic [TW-1:0] i_reg, i_next;
    logic [TW-1:0] pa_reg, pa_next;
    logic [TW-1:0] head_reg, head_next;

    // Datapath
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] pred_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic [COEF_W-1:0]          step_reg;
    logic                       big_reg;
    logic signed [SE_W-1:0]     se_reg;
    logic signed [MUL_W-1:0]    mul_reg;
    logic signed [WEIGHT_W-1:0] wd_reg;
    logic [TW-1:0]              wa_reg;
    logic                       acc_pend_reg;
    logic                       upd_pend_reg;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_W-1:0]    mul_prod;

    // Tap memories with per-entry valid bits standing in for the reset image
    logic signed [WEIGHT_W-1:0] wmem [TAPS];
    logic signed [SAMPLE_W-1:0] pmem [TAPS];
    logic [TAPS-1:0]            w_valid_reg;
    logic [TAPS-1:0]            p_valid_reg;
    logic signed [WEIGHT_W-1:0] w_rd_reg;
    logic signed [SAMPLE_W-1:0] p_rd_reg;
    logic                       w_rd_valid_reg;
    logic                       w_rd_first_reg;
    logic                       p_rd_valid_reg;
    logic signed [WEIGHT_W-1:0] w_eff;
    logic signed [SAMPLE_W-1:0] p_eff;

    // Rounding and saturation
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [Q_W-1:0]      acc_q;
    logic signed [SAMPLE_W-1:0] pred_sat;
    logic signed [ERR_W-1:0]    err_calc;
    logic [EXP_W-1:0]           exp_val;
    logic [EXP_W-1:0]           one_minus;
    logic signed [MUL_W-1:0]    upd_rnd;
    logic signed [UPD_D_W-1:0]  upd_d;
    logic signed [UPD_D_W-1:0]  wsum;
    logic signed [WEIGHT_W-1:0] w_new;

    // Output register
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;

    logic in_fire;
    logic out_free;
    logic out_go;

    assign uc       = ucode_rom(upc_reg);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign out_go   = (upc_reg == UP_OUT) && out_free;

    assign s_axis_tready = (upc_reg == UP_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Register port: always ready, write on the access phase
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_MODE:       prdata = CFG_DATA_W'(mode_reg);
            REG_FIXED_STEP: prdata = CFG_DATA_W'(fixed_step_reg);
            REG_EXP_GAIN:   prdata = CFG_DATA_W'(exp_gain_reg);
            REG_STEP_CEIL:  prdata = CFG_DATA_W'(step_ceil_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            fixed_step_reg <= FIXED_STEP_RST;
            exp_gain_reg   <= EXP_GAIN_RST;
            step_ceil_reg  <= STEP_CEIL_RST;
        end
        else if (cfg_wr && pready)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_MODE:       mode_reg       <= pwdata[0];
                REG_FIXED_STEP: fixed_step_reg <= pwdata[COEF_W-1:0];
                REG_EXP_GAIN:   exp_gain_reg   <= pwdata[COEF_W-1:0];
                REG_STEP_CEIL:  step_ceil_reg  <= pwdata[COEF_W-1:0];
                default:        mode_reg       <= mode_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next step from the control word's sequencing field
    // ------------------------------------------------------------------
    always_comb
    begin
        case (uc.seq)
            SEQ_NEXT:      upc_next = upc_t'(4'(upc_reg) + 4'd1);
            SEQ_GOTO:      upc_next = uc.target;
            SEQ_LOOP:      upc_next = (cnt_reg == LAST) ? upc_t'(4'(upc_reg) + 4'd1)
                                                        : upc_reg;
            SEQ_WAIT_IN:   upc_next = in_fire ? upc_t'(4'(upc_reg) + 4'd1) : upc_reg;
            SEQ_WAIT_OUT:  upc_next = out_free ? uc.target : upc_reg;
            SEQ_JMP_FIXED: upc_next = mode_reg ? upc_t'(4'(upc_reg) + 4'd1) : uc.target;
            default:       upc_next = UP_IDLE;
        endcase
    end

    // Control outputs: counters and address steering
    always_comb
    begin
        if ((uc.seq == SEQ_LOOP) && (cnt_reg != LAST))
            cnt_next = cnt_reg + 1'b1;
        else
            cnt_next = '0;

        if (uc.rewind)
            i_next = '0;
        else if (uc.adv)
            i_next = (i_reg == LAST) ? '0 : i_reg + 1'b1;
        else
            i_next = i_reg;

        if (uc.rewind)
            pa_next = head_reg;
        else if (uc.adv)
            pa_next = (pa_reg == LAST) ? '0 : pa_reg + 1'b1;
        else
            pa_next = pa_reg;

        // Drop the oldest sample: the newest takes the slot before the head
        if (uc.act == ACT_SHIFT)
            head_next = (head_reg == '0) ? LAST : head_reg - 1'b1;
        else
            head_next = head_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg        <= UP_IDLE;
            cnt_reg        <= '0;
            i_reg          <= '0;
            pa_reg         <= '0;
            head_reg       <= '0;
            acc_pend_reg   <= 1'b0;
            upd_pend_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            w_valid_reg    <= '0;
            p_valid_reg    <= '0;
            w_rd_valid_reg <= 1'b0;
            w_rd_first_reg <= 1'b0;
            p_rd_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg      <= upc_next;
            cnt_reg      <= cnt_next;
            i_reg        <= i_next;
            pa_reg       <= pa_next;
            head_reg     <= head_next;
            acc_pend_reg <= uc.mac;
            upd_pend_reg <= uc.upd;

            if (out_go)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (upd_pend_reg)
                w_valid_reg[wa_reg] <= 1'b1;
            if (uc.act == ACT_SHIFT)
                p_valid_reg[head_next] <= 1'b1;

            w_rd_valid_reg <= w_valid_reg[i_next];
            w_rd_first_reg <= (i_next == '0);
            p_rd_valid_reg <= p_valid_reg[pa_next];
        end
    end

    // ------------------------------------------------------------------
    // Tap memories: one write port and one registered read port each
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (upd_pend_reg)
            wmem[wa_reg] <= w_new;
        w_rd_reg <= wmem[i_next];
    end

    always_ff @(posedge clk)
    begin
        if (uc.act == ACT_SHIFT)
            pmem[head_next] <= x_reg;
        p_rd_reg <= pmem[pa_next];
    end

    // Unwritten entries read as their reset image
    assign w_eff = w_rd_valid_reg ? w_rd_reg : (w_rd_first_reg ? WEIGHT_ONE : '0);
    assign p_eff = p_rd_valid_reg ? p_rd_reg : '0;

    // ------------------------------------------------------------------
    // Shared multiplier operand select
    // ------------------------------------------------------------------
    assign exp_val   = big_reg ? '0 : EXP_ROM[mul_reg[EXP_SHIFT +: EXP_IDX_W]];
    assign one_minus = EXP_ONE - exp_val;

    always_comb
    begin
        case (uc.mul)
            MUL_WP:
            begin
                mul_a = MUL_A_W'(w_eff);
                mul_b = MUL_B_W'(p_eff);
            end
            MUL_EE:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(err_reg);
            end
            MUL_GAIN:
            begin
                mul_a = signed'(MUL_A_W'(mul_reg[31:0]));
                mul_b = signed'(MUL_B_W'(exp_gain_reg));
            end
            MUL_DEPTH:
            begin
                mul_a = signed'(MUL_A_W'(mul_reg[EXP_SHIFT-1:0]));
                mul_b = signed'(MUL_B_W'(EXP_DEPTH));
            end
            MUL_CEIL:
            begin
                mul_a = signed'(MUL_A_W'(one_minus));
                mul_b = signed'(MUL_B_W'(step_ceil_reg));
            end
            MUL_SE:
            begin
                mul_a = signed'(MUL_A_W'(step_reg));
                mul_b = MUL_B_W'(err_reg);
            end
            MUL_UPD:
            begin
                mul_a = MUL_A_W'(se_reg);
                mul_b = MUL_B_W'(p_eff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Prediction: round the Q9.43 sum (at TAPS=8) to Q1.15, saturate, form the error
    // ------------------------------------------------------------------
    assign acc_rnd = acc_reg + ACC_HALF;
    assign acc_q   = signed'(acc_rnd[ACC_W-1:PRED_SHIFT]);

    always_comb
    begin
        if (!acc_q[Q_W-1] && (|acc_q[Q_W-2:SAMPLE_W-1]))
            pred_sat = {1'b0, {(SAMPLE_W - 1){1'b1}}};
        else if (acc_q[Q_W-1] && !(&acc_q[Q_W-2:SAMPLE_W-1]))
            pred_sat = {1'b1, {(SAMPLE_W - 1){1'b0}}};
        else
            pred_sat = acc_q[SAMPLE_W-1:0];
    end

    assign err_calc = ERR_W'(x_reg) - ERR_W'(pred_sat);

    // ------------------------------------------------------------------
    // Weight update: round to Q4.28 and saturate the new weight
    // ------------------------------------------------------------------
    assign upd_rnd = mul_reg + UPD_HALF;
    assign upd_d   = signed'(upd_rnd[UPD_SHIFT + UPD_D_W - 1:UPD_SHIFT]);
    assign wsum    = UPD_D_W'(wd_reg) + upd_d;

    always_comb
    begin
        if (!wsum[UPD_D_W-1] && (wsum[UPD_D_W-2] || wsum[WEIGHT_W-1]))
            w_new = WEIGHT_MAX;
        else if (wsum[UPD_D_W-1] && !(wsum[UPD_D_W-2] && wsum[WEIGHT_W-1]))
            w_new = WEIGHT_MIN;
        else
            w_new = wsum[WEIGHT_W-1:0];
    end

    // ------------------------------------------------------------------
    // Datapath registers, steered by the control word
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_prod;
        wd_reg  <= w_eff;
        wa_reg  <= i_reg;

        // Clear the sum on accept, then add each registered product in the cycle after its multiply
        if ((uc.act == ACT_LOAD) && in_fire)
        begin
            x_reg   <= signed'(s_axis_tdata);
            acc_reg <= '0;
        end
        else if (acc_pend_reg)
        begin
            acc_reg <= acc_reg + signed'(mul_reg[ACC_W-1:0]);
        end

        case (uc.act)
            ACT_PRED:
            begin
                pred_reg <= pred_sat;
                err_reg  <= err_calc;
                step_reg <= fixed_step_reg;
            end
            // Argument beyond the table: take the exponential as zero
            ACT_BIG:  big_reg  <= |mul_reg[GAIN_PROD_W-1:EXP_SHIFT];
            ACT_STEP: step_reg <= mul_reg[2*COEF_W-1:COEF_W];
            ACT_SE:   se_reg   <= mul_reg[SE_W-1:0];
            ACT_OUT:
            begin
                if (out_free)
                    out_data_reg <= pred_reg;
            end
            default:  big_reg  <= big_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `LMS_AP_ASSERT_NEXT(a_accept_starts_mac, in_fire, upc_reg == UP_PMAC, "accept did not start the tap walk")
    `LMS_AP_ASSERT(a_acc_window, acc_pend_reg |-> (upc_reg == UP_PMAC || upc_reg == UP_PDRAIN), "accumulate outside the prediction walk")
    `LMS_AP_ASSERT(a_wr_window, upd_pend_reg |-> (upc_reg == UP_UMAC || upc_reg == UP_UDRAIN), "weight write outside the update walk")
    `LMS_AP_ASSERT_NEXT(a_result_posted, out_go, m_axis_tvalid, "finished prediction not posted")
    `LMS_AP_ASSERT(a_head_on_shift, !$stable(head_reg) |-> ($past(upc_reg) == UP_SHIFT), "delay line head moved outside the shift step")

endmodule

### dv/lms_adaptive_predictor_unit_tb.sv
// Self-checking testbench of the LMS adaptive predictor: sample stream in, prediction stream out.
`timescale 1ns / 1ps

module lms_adaptive_predictor_unit_tb;

    import lms_ap_pkg::*;

    localparam int TAPS               = 8;
    localparam int DRAIN_CYCLES       = 40;    // covers the variable-step latency
    localparam int QUIET_LIMIT        = 2000;  // cycles without any handshake on a stream or the register port
    localparam int RANDOM_PHASES      = 8;
    localparam int SAMPLES_PER_PHASE  = 72;
    localparam int MAX_REPORTS        = 40;
    localparam longint PRED_HALF      = longint'(1) <<< (PRED_SHIFT - 1);
    localparam longint UPD_HALF       = longint'(1) <<< (UPD_SHIFT - 1);
    localparam longint WEIGHT_HI      = 64'sd2147483647;
    localparam longint WEIGHT_LO      = -64'sd2147483648;

    // Directed rows: a sample with a typed-in result, a sample checked by the
    // predictor, or a register write.
    typedef enum logic [1:0] {
        ROW_KNOWN,
        ROW_MODEL,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        reg_idx_t    target;
        logic [31:0] value;
        logic [15:0] expected;
    } stim_row_t;

    // Shapes of the random sample stream
    typedef enum logic [2:0] {
        SRC_WALK,
        SRC_PERIODIC,
        SRC_NOISE,
        SRC_EXTREME,
        SRC_SMALL
    } sample_src_t;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_kind_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata;    // [15:0] sample
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_axis_tdata;    // [15:0] prediction

    // Predictor state: weights Q4.28, delay line Q1.15 (entry 0 newest)
    int                   model_weight [TAPS];
    logic signed [15:0]   model_history [TAPS];
    int unsigned          exp_lut [EXP_DEPTH];
    logic                 cfg_mode;
    logic [15:0]          cfg_fixed_step;
    logic [15:0]          cfg_gain;
    logic [15:0]          cfg_ceiling;

    logic [15:0]          pending_predictions [$];
    int                   mismatch_count = 0;
    int                   quiet_cycles = 0;

    // Random stream state
    int                   walk_level = 0;
    int                   walk_stride = 64;
    logic [15:0]          period_buf [8];
    int                   period_len = 4;
    int                   period_pos = 0;

    stall_kind_t          stall_kind = STALL_NONE;
    int                   stall_left = 0;
    int                   stall_tick = 0;

    lms_adaptive_predictor_unit #(
        .TAPS (TAPS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // exp(-8k/depth) in Q1.16: Taylor ratio in Q0.32, then repeated products
    function automatic void fill_exp_lut();
        longint unsigned term;
        longint unsigned plus;
        longint unsigned minus;
        longint unsigned ratio;
        longint unsigned acc_e;
        int n;
        int k;
        term  = 64'd1 << 32;
        plus  = term;
        minus = 64'd0;
        for (n = 1; n < 12; n++)
        begin
            term = (term * 64'd8) / (64'(EXP_DEPTH) * 64'(n));
            if (n % 2 == 1)
                minus += term;
            else
                plus += term;
        end
        ratio = plus - minus;
        acc_e = 64'd1 << 32;
        for (k = 0; k < EXP_DEPTH; k++)
        begin
            if (k > 0)
                acc_e = (acc_e * ratio + (64'd1 << 31)) >> 32;
            exp_lut[k] = 32'((acc_e + (64'd1 << 15)) >> 16);
        end
    endfunction

    // Predict one sample, adapt the weights and shift the delay line.
    function automatic logic [15:0] lms_predict_update(input logic signed [15:0] smp);
        longint          acc;
        longint          pred;
        longint          err;
        longint          mu;
        longint          corr;
        longint          w;
        longint unsigned sq;
        longint unsigned arg;
        longint unsigned lut_idx;
        longint unsigned e_val;
        int              i;
        acc = 0;
        for (i = 0; i < TAPS; i++)
            acc += longint'(model_weight[i]) * longint'(model_history[i]);
        pred = (acc + PRED_HALF) >>> PRED_SHIFT;
        if (pred > 32767)
            pred = 32767;
        else if (pred < -32768)
            pred = -32768;
        // the saturated prediction also feeds the error
        err = longint'(smp) - pred;

        if (cfg_mode)
        begin
            sq      = err * err;
            arg     = sq * cfg_gain;
            lut_idx = (arg * EXP_DEPTH) >> EXP_SHIFT;
            // past the end of the table exp is taken as zero, so the step is beta
            e_val   = (lut_idx < EXP_DEPTH) ? exp_lut[lut_idx] : 64'd0;
            mu      = (64'(cfg_ceiling) * (64'd65536 - e_val)) >> 16;
        end
        else
            mu = cfg_fixed_step;

        for (i = 0; i < TAPS; i++)
        begin
            corr = (mu * err * longint'(model_history[i]) + UPD_HALF) >>> UPD_SHIFT;
            w    = longint'(model_weight[i]) + corr;
            if (w > WEIGHT_HI)
                w = WEIGHT_HI;
            else if (w < WEIGHT_LO)
                w = WEIGHT_LO;
            model_weight[i] = int'(w);
        end

        for (i = TAPS - 1; i > 0; i--)
            model_history[i] = model_history[i - 1];
        model_history[0] = smp;
        return pred[15:0];
    endfunction

    // Offer one sample request; hold it until accepted, then record what to expect.
    // Returns at the accepting edge without touching tvalid, so a following
    // request keeps tvalid high.
    task automatic send_sample(input logic [15:0] smp, input bit typed,
                               input logic [15:0] typed_value);
        logic [15:0] predicted;
        s_axis_tdata  <= smp;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = lms_predict_update(smp);
        pending_predictions.push_back(typed ? typed_value : predicted);
    endtask

    // Drop tvalid, wait until every prediction is back and the pipeline is empty.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (pending_predictions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write followed by a read back of the same register.
    task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] readback;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        // bits above the register width are dropped
        case (idx)
            REG_MODE:       cfg_mode       = value[0];
            REG_FIXED_STEP: cfg_fixed_step = value[15:0];
            REG_EXP_GAIN:   cfg_gain       = value[15:0];
            REG_STEP_CEIL:  cfg_ceiling    = value[15:0];
            default: ;
        endcase
        @(posedge clk);

        pwrite  <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_MODE:       readback = {31'd0, cfg_mode};
            REG_FIXED_STEP: readback = {16'd0, cfg_fixed_step};
            REG_EXP_GAIN:   readback = {16'd0, cfg_gain};
            default:        readback = {16'd0, cfg_ceiling};
        endcase
        if (prdata !== readback)
            report_mismatch($sformatf("register %s read %h, want %h",
                                      idx.name(), prdata, readback));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Coefficient values with the extremes well represented.
    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 64));
            3:       return 16'($urandom_range(256, 2048));
            default: return 16'($urandom());
        endcase
    endfunction

    // Prepare the generator for a new burst of the given shape.
    function automatic void start_burst(input sample_src_t src);
        int i;
        int amp;
        if (src == SRC_WALK)
            walk_stride = $urandom_range(4, 3000);
        else if (src == SRC_PERIODIC && $urandom_range(0, 2) == 0)
        begin
            period_len = $urandom_range(2, 8);
            period_pos = 0;
            amp = $urandom_range(100, 32767);
            for (i = 0; i < 8; i++)
                period_buf[i] = 16'($urandom_range(0, 2 * amp) - amp);
        end
    endfunction

    function automatic logic [15:0] next_sample(input sample_src_t src);
        logic [15:0] v;
        case (src)
            SRC_WALK:
            begin
                walk_level += $urandom_range(0, 2 * walk_stride) - walk_stride;
                if (walk_level > 32767)
                    walk_level = 32767;
                else if (walk_level < -32768)
                    walk_level = -32768;
                v = 16'(walk_level);
            end
            SRC_PERIODIC:
            begin
                v = period_buf[period_pos];
                period_pos = (period_pos + 1) % period_len;
            end
            SRC_EXTREME:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 16'h7FFF;
                    1:       v = 16'h8000;
                    2:       v = 16'h0000;
                    3:       v = 16'hFFFF;
                    default: v = 16'h0001;
                endcase
            end
            SRC_SMALL: v = 16'($urandom_range(0, 512) - 256);
            default:   v = 16'($urandom());
        endcase
        return v;
    endfunction

    function automatic sample_src_t pick_source();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return SRC_WALK;
        if (r < 65)
            return SRC_PERIODIC;
        if (r < 80)
            return SRC_NOISE;
        if (r < 90)
            return SRC_EXTREME;
        return SRC_SMALL;
    endfunction

    // Result side: compare each accepted prediction with the oldest expectation,
    // then pick tready for the next edge from the current stall pattern.
    always @(posedge clk)
    begin
        logic [15:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_predictions.size() == 0)
                report_mismatch($sformatf("prediction %h with no sample pending",
                                          m_axis_tdata));
            else
            begin
                want = pending_predictions.pop_front();
                if (m_axis_tdata !== want)
                    report_mismatch($sformatf("prediction %h, want %h", m_axis_tdata, want));
            end
        end

        if (stall_left == 0)
        begin
            stall_kind = stall_kind_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 200);
            stall_tick = 0;
        end
        stall_left--;
        stall_tick++;
        case (stall_kind)
            STALL_NONE:     m_axis_tready <= 1'b1;
            STALL_RANDOM:   m_axis_tready <= ($urandom_range(0, 1) == 1);
            STALL_HEAVY:    m_axis_tready <= ($urandom_range(0, 7) == 0);
            default:        m_axis_tready <= (stall_tick % 37) < 5;
        endcase
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable && pready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("lms_adaptive_predictor_unit_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t   directed_rows [$];
        stim_row_t   row;
        sample_src_t src;
        logic [31:0] junk;
        int          phase;
        int          sent;
        int          burst;
        int          gap;
        int          i;

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        // Predictor after reset: register defaults, weight 0 = 1.0, empty delay line
        fill_exp_lut();
        cfg_mode       = 1'b0;
        cfg_fixed_step = FIXED_STEP_RST;
        cfg_gain       = EXP_GAIN_RST;
        cfg_ceiling    = STEP_CEIL_RST;
        for (i = 0; i < TAPS; i++)
        begin
            model_weight[i]  = 0;
            model_history[i] = '0;
        end
        model_weight[0] = 1 << PRED_SHIFT;

        // Directed table. First two results follow from reset directly: an empty
        // delay line predicts zero, then weight 0 = 1.0 repeats the first sample.
        directed_rows.push_back(stim_row_t'{ROW_KNOWN, REG_MODE, 32'h0000_7FFF, 16'h0000});
        directed_rows.push_back(stim_row_t'{ROW_KNOWN, REG_MODE, 32'h0000_8000, 16'h7FFF});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_0000, 16'h0000});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_0001, 16'h0000});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_FFFF, 16'h0000});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_5555, 16'h0000});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_AAAA, 16'h0000});
        // zero step with junk in the upper bits: weights freeze
        directed_rows.push_back(stim_row_t'{ROW_WRITE, REG_FIXED_STEP, 32'hFFFF_0000, 16'h0});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_7FFF, 16'h0000});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_8000, 16'h0000});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_8000, 16'h0000});
        // largest fixed step on full-scale swings: weights and predictions saturate
        directed_rows.push_back(stim_row_t'{ROW_WRITE, REG_FIXED_STEP, 32'h0000_FFFF, 16'h0});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_7FFF, 16'h0000});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_8000, 16'h0000});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_7FFF, 16'h0000});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_8000, 16'h0000});
        // variable step with the largest gain: argument runs past the table, step = beta
        directed_rows.push_back(stim_row_t'{ROW_WRITE, REG_MODE, 32'hFFFF_FFFF, 16'h0});
        directed_rows.push_back(stim_row_t'{ROW_WRITE, REG_EXP_GAIN, 32'hA5A5_FFFF, 16'h0});
        directed_rows.push_back(stim_row_t'{ROW_WRITE, REG_STEP_CEIL, 32'h5A5A_FFFF, 16'h0});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_7FFF, 16'h0000});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_8000, 16'h0000});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_0000, 16'h0000});
        // zero gain: table entry 0 gives a zero step
        directed_rows.push_back(stim_row_t'{ROW_WRITE, REG_EXP_GAIN, 32'h0000_0000, 16'h0});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_04D2, 16'h0000});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_FB2E, 16'h0000});
        // mid-table gain, zero ceiling, then back to fixed mode via a masked write
        directed_rows.push_back(stim_row_t'{ROW_WRITE, REG_EXP_GAIN, 32'h0000_0100, 16'h0});
        directed_rows.push_back(stim_row_t'{ROW_WRITE, REG_STEP_CEIL, 32'h0000_0000, 16'h0});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_0064, 16'h0000});
        directed_rows.push_back(stim_row_t'{ROW_WRITE, REG_MODE, 32'hFFFF_FFFE, 16'h0});
        directed_rows.push_back(stim_row_t'{ROW_MODEL, REG_MODE, 32'h0000_0064, 16'h0000});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; a short random gap now and then.
        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            if (row.kind == ROW_WRITE)
            begin
                quiesce();
                write_register(row.target, row.value);
            end
            else
            begin
                send_sample(row.value[15:0], row.kind == ROW_KNOWN, row.expected);
                if ($urandom_range(0, 2) == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge clk);
                end
            end
        end

        // Random phases: fresh settings each phase, mode alternating, then bursts
        // of shaped sample streams with random gaps.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            quiesce();
            junk    = $urandom();
            junk[0] = phase[0];
            write_register(REG_MODE, junk);
            junk = $urandom();
            write_register(REG_FIXED_STEP, {junk[31:16], pick_coef()});
            junk = $urandom();
            write_register(REG_EXP_GAIN, {junk[31:16], pick_coef()});
            junk = $urandom();
            write_register(REG_STEP_CEIL, {junk[31:16], pick_coef()});

            sent = 0;
            while (sent < SAMPLES_PER_PHASE)
            begin
                src   = pick_source();
                burst = $urandom_range(1, 24);
                start_burst(src);
                for (i = 0; i < burst; i++)
                begin
                    send_sample(next_sample(src), 1'b0, 16'h0000);
                    sent++;
                end
                if ($urandom_range(0, 11) == 0)
                begin
                    // hold off until every prediction is back
                    s_axis_tvalid <= 1'b0;
                    do
                        @(posedge clk);
                    while (pending_predictions.size() != 0);
                end
                else if ($urandom_range(0, 3) != 0)
                begin
                    gap = $urandom_range(1, 30);
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        // Drain and allow a tail for any stray result.
        s_axis_tvalid <= 1'b0;
        while (pending_predictions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("lms_adaptive_predictor_unit_tb OK");
        else
            $display("lms_adaptive_predictor_unit_tb NOT OK");
        $finish;
    end

endmodule

### lms_adaptive_predictor_unit.f
+incdir+design
design/lms_ap_pkg.sv
design/lms_adaptive_predictor_unit.sv
dv/lms_adaptive_predictor_unit_tb.sv
